FILE: rtl/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// Shared constants and helpers for the integer literal parser: parse phase
// codes, radix codes, register indexes, character codes and keyword tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ilp_pkg;

	// parse phase codes
	localparam logic [2:0] PH_START      = 3'd0;
	localparam logic [2:0] PH_BODY0      = 3'd1;
	localparam logic [2:0] PH_FIRSTDIG   = 3'd2;
	localparam logic [2:0] PH_AFTER_ZERO = 3'd3;
	localparam logic [2:0] PH_DIGITS     = 3'd4;
	localparam logic [2:0] PH_KEYWORD    = 3'd5;

	// radix codes
	localparam logic [1:0] RADIX_DEC = 2'd0;
	localparam logic [1:0] RADIX_BIN = 2'd1;
	localparam logic [1:0] RADIX_OCT = 2'd2;
	localparam logic [1:0] RADIX_HEX = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_DETECT_BASE = 2'd0;
	localparam logic [1:0] REG_WIDTH_SEL   = 2'd1;
	localparam logic [1:0] REG_IS_SIGNED   = 2'd2;

	// keyword ids (zero means no keyword candidate)
	localparam logic [1:0] KW_NONE  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_NULL  = 2'd2;
	localparam logic [1:0] KW_TRUE  = 2'd3;

	// character codes and masks
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_LO_B    = 8'h62;
	localparam logic [7:0] CH_LO_F    = 8'h66;
	localparam logic [7:0] CH_LO_N    = 8'h6E;
	localparam logic [7:0] CH_LO_O    = 8'h6F;
	localparam logic [7:0] CH_LO_T    = 8'h74;
	localparam logic [7:0] CH_LO_X    = 8'h78;
	localparam logic [7:0] UPPER_MASK = 8'hDF;
	localparam logic [7:0] LOWER_BIT  = 8'h20;
	localparam logic [7:0] ALPHA_OFS  = 8'd10;

	// largest magnitude allowed for width, signedness and sign
	function automatic logic [63:0] mag_limit(input logic [1:0] wsel, input logic sgn,
			input logic neg);
		logic [63:0] half;
		unique case (wsel)
			2'd0:    half = 64'h0000_0000_0000_0080;
			2'd1:    half = 64'h0000_0000_0000_8000;
			2'd2:    half = 64'h0000_0000_8000_0000;
			default: half = 64'h8000_0000_0000_0000;
		endcase
		if (neg)
			return half;
		else if (sgn)
			return half - 64'd1;
		else
			return (half << 1) - 64'd1;
	endfunction

	// keyword length by id
	function automatic logic [2:0] kw_len(input logic [1:0] id);
		unique case (id)
			KW_FALSE: return 3'd5;
			KW_NULL:  return 3'd4;
			KW_TRUE:  return 3'd4;
			default:  return 3'd0;
		endcase
	endfunction

	// expected keyword character by id and position
	function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] pos);
		logic [39:0] text;
		unique case (id)
			KW_FALSE: text = 40'h65_73_6C_61_66; // "false", first char lowest
			KW_NULL:  text = 40'h00_6C_6C_75_6E; // "null"
			KW_TRUE:  text = 40'h00_65_75_72_74; // "true"
			default:  text = 40'h0;
		endcase
		unique case (pos)
			3'd0:    return text[7:0];
			3'd1:    return text[15:8];
			3'd2:    return text[23:16];
			3'd3:    return text[31:24];
			3'd4:    return text[39:32];
			default: return 8'h00;
		endcase
	endfunction

endpackage

`default_nettype wire

FILE: rtl/integer_literal_parser.sv
// ----------------------------------------------------------------------------
// integer_literal_parser
// Streaming text-to-integer converter with sign, base prefixes, underscores,
// range checking and the keywords false, null and true.
// ----------------------------------------------------------------------------
// One character enters per beat and the block takes a new beat in every cycle
// while the input side is not stalled. Each beat is held in an input register;
// a single step of accumulate (shift-add by 2, 8, 10 or 16) and limit compare
// then updates the parse state, and the beat that ends a string loads the
// result register. The input side stalls only while a finished result waits
// in the output register and the held beat would produce another one.
// Configuration writes take effect on the next clock edge.
`default_nettype none

module integer_literal_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [1:0]  cfg_wdata,
	// input characters
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] ch
	input  wire logic        s_tuser,  // [0] has_char
	input  wire logic        s_tlast,  // last
	// parse results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // [63:0] value
	output logic             m_tuser   // [0] ok
);

	// configuration registers
	logic       detect_q;
	logic [1:0] width_q;
	logic       signed_q;

	// input stage
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       has_s1;
	logic       last_s1;
	logic       adv_s1;

	// parse state
	logic [63:0] accum_q;
	logic [2:0]  phase_q;
	logic        neg_q;
	logic [1:0]  radix_q;
	logic        prev_us_q;
	logic [1:0]  kw_id_q;
	logic [2:0]  kw_pos_q;
	logic        failed_q;

	// next parse state
	logic [63:0] accum_n;
	logic [2:0]  phase_n;
	logic        neg_n;
	logic [1:0]  radix_n;
	logic        prev_us_n;
	logic [1:0]  kw_id_n;
	logic [2:0]  kw_pos_n;
	logic        failed_n;

	// digit step signals
	logic        body_first;
	logic        dig_do;
	logic        dig_first;
	logic [7:0]  low_ch;
	logic [7:0]  up_ch;
	logic [7:0]  dval;
	logic [7:0]  base;
	logic        is_dec;
	logic        is_alpha;
	logic        dig_ok;
	logic [68:0] prod;
	logic [63:0] lim;
	logic        dig_acc;

	// result
	logic        res_ok;
	logic [63:0] res_val;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_q <= 1'b0;
			width_q  <= 2'd3;
			signed_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ilp_pkg::REG_DETECT_BASE: detect_q <= cfg_wdata[0];
				ilp_pkg::REG_WIDTH_SEL:   width_q  <= cfg_wdata;
				ilp_pkg::REG_IS_SIGNED:   signed_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input stage handshake
	assign adv_s1   = valid_s1 && (!last_s1 || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1   <= s_tdata;
			has_s1  <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	// digit decode and scaled accumulate; the radix is decimal at the body start
	always_comb begin
		up_ch    = ch_s1 & ilp_pkg::UPPER_MASK;
		is_dec   = (ch_s1 >= ilp_pkg::CH_ZERO) && (ch_s1 <= ilp_pkg::CH_NINE);
		is_alpha = (up_ch >= ilp_pkg::CH_UP_A) && (up_ch <= ilp_pkg::CH_UP_Z);
		dval     = is_dec ? (ch_s1 - ilp_pkg::CH_ZERO)
		                  : (up_ch - ilp_pkg::CH_UP_A + ilp_pkg::ALPHA_OFS);
		unique case (radix_q)
			ilp_pkg::RADIX_DEC: begin
				base = 8'd10;
				prod = {2'b0, accum_q, 3'b0} + {4'b0, accum_q, 1'b0};
			end
			ilp_pkg::RADIX_BIN: begin
				base = 8'd2;
				prod = {4'b0, accum_q, 1'b0};
			end
			ilp_pkg::RADIX_OCT: begin
				base = 8'd8;
				prod = {2'b0, accum_q, 3'b0};
			end
			default: begin
				base = 8'd16;
				prod = {1'b0, accum_q, 4'b0};
			end
		endcase
		dig_ok = (is_dec || is_alpha) && (dval < base);
		prod   = prod + {61'b0, dval};
	end

	// parse step for the held character
	always_comb begin
		accum_n    = accum_q;
		phase_n    = phase_q;
		neg_n      = neg_q;
		radix_n    = radix_q;
		prev_us_n  = prev_us_q;
		kw_id_n    = kw_id_q;
		kw_pos_n   = kw_pos_q;
		failed_n   = failed_q;
		body_first = 1'b0;
		dig_do     = 1'b0;
		dig_first  = 1'b0;
		dig_acc    = 1'b0;
		low_ch     = ch_s1 | ilp_pkg::LOWER_BIT;

		// phase decode
		if (has_s1 && !failed_q) begin
			unique case (phase_q)
				ilp_pkg::PH_START: begin
					if (ch_s1 == ilp_pkg::CH_MINUS || ch_s1 == ilp_pkg::CH_PLUS) begin
						neg_n   = (ch_s1 == ilp_pkg::CH_MINUS);
						phase_n = ilp_pkg::PH_BODY0;
					end else begin
						body_first = 1'b1;
					end
				end
				ilp_pkg::PH_BODY0: body_first = 1'b1;
				ilp_pkg::PH_AFTER_ZERO: begin
					if (detect_q && (low_ch == ilp_pkg::CH_LO_B || low_ch == ilp_pkg::CH_LO_O
							|| low_ch == ilp_pkg::CH_LO_X)) begin
						if (last_s1) begin
							failed_n = 1'b1;
						end else begin
							priority if (low_ch == ilp_pkg::CH_LO_B) radix_n = ilp_pkg::RADIX_BIN;
							else if (low_ch == ilp_pkg::CH_LO_O)     radix_n = ilp_pkg::RADIX_OCT;
							else                                     radix_n = ilp_pkg::RADIX_HEX;
							accum_n   = 64'd0;
							prev_us_n = 1'b0;
							phase_n   = ilp_pkg::PH_FIRSTDIG;
						end
					end else begin
						phase_n = ilp_pkg::PH_DIGITS;
						dig_do  = 1'b1;
					end
				end
				ilp_pkg::PH_FIRSTDIG: begin
					phase_n   = ilp_pkg::PH_DIGITS;
					dig_do    = 1'b1;
					dig_first = 1'b1;
				end
				ilp_pkg::PH_DIGITS: dig_do = 1'b1;
				ilp_pkg::PH_KEYWORD: begin
					if (kw_id_q == ilp_pkg::KW_NONE || kw_pos_q >= ilp_pkg::kw_len(kw_id_q)
							|| ch_s1 != ilp_pkg::kw_char(kw_id_q, kw_pos_q))
						failed_n = 1'b1;
					else
						kw_pos_n = kw_pos_q + 3'd1;
				end
				default: failed_n = 1'b1;
			endcase
		end

		// first body character: digit or keyword start
		if (body_first) begin
			if (is_dec) begin
				radix_n   = ilp_pkg::RADIX_DEC;
				dig_do    = 1'b1;
				dig_first = 1'b1;
				phase_n   = (ch_s1 == ilp_pkg::CH_ZERO) ? ilp_pkg::PH_AFTER_ZERO
				                                        : ilp_pkg::PH_DIGITS;
			end else if (ch_s1 == ilp_pkg::CH_LO_F) begin
				kw_id_n  = ilp_pkg::KW_FALSE;
				kw_pos_n = 3'd1;
				phase_n  = ilp_pkg::PH_KEYWORD;
			end else if (ch_s1 == ilp_pkg::CH_LO_N) begin
				kw_id_n  = ilp_pkg::KW_NULL;
				kw_pos_n = 3'd1;
				phase_n  = ilp_pkg::PH_KEYWORD;
			end else if (ch_s1 == ilp_pkg::CH_LO_T) begin
				kw_id_n  = ilp_pkg::KW_TRUE;
				kw_pos_n = 3'd1;
				phase_n  = ilp_pkg::PH_KEYWORD;
			end else begin
				failed_n = 1'b1;
			end
		end

		// digit accumulate with exact overflow check
		lim = ilp_pkg::mag_limit(width_q, signed_q, neg_n);
		if (dig_do) begin
			if (neg_n && !signed_q) begin
				if (ch_s1 != ilp_pkg::CH_ZERO)
					failed_n = 1'b1;
				prev_us_n = 1'b0;
			end else if (dig_ok && prod <= {5'b0, lim}) begin
				accum_n   = prod[63:0];
				prev_us_n = 1'b0;
				dig_acc   = 1'b1;
			end else if (dig_first || ch_s1 != ilp_pkg::CH_UNDER || prev_us_q) begin
				failed_n = 1'b1;
			end else begin
				prev_us_n = 1'b1;
			end
		end
	end

	// end of string result
	always_comb begin
		res_ok  = 1'b0;
		res_val = 64'd0;
		if (!failed_n) begin
			if (phase_n == ilp_pkg::PH_DIGITS || phase_n == ilp_pkg::PH_AFTER_ZERO) begin
				if (!prev_us_n) begin
					if (neg_n && !signed_q) begin
						res_ok = 1'b1;
					end else if (dig_acc || accum_q <= lim) begin
						res_ok  = 1'b1;
						res_val = neg_n ? (64'd0 - accum_n) : accum_n;
					end
				end
			end else if (phase_n == ilp_pkg::PH_KEYWORD && kw_id_n != ilp_pkg::KW_NONE
					&& kw_pos_n == ilp_pkg::kw_len(kw_id_n)) begin
				res_ok  = 1'b1;
				res_val = (kw_id_n == ilp_pkg::KW_TRUE) ? 64'd1 : 64'd0;
			end
		end
	end

	// parse state registers, cleared after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q   <= 64'd0;
			phase_q   <= ilp_pkg::PH_START;
			neg_q     <= 1'b0;
			radix_q   <= ilp_pkg::RADIX_DEC;
			prev_us_q <= 1'b0;
			kw_id_q   <= ilp_pkg::KW_NONE;
			kw_pos_q  <= 3'd0;
			failed_q  <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				accum_q   <= 64'd0;
				phase_q   <= ilp_pkg::PH_START;
				neg_q     <= 1'b0;
				radix_q   <= ilp_pkg::RADIX_DEC;
				prev_us_q <= 1'b0;
				kw_id_q   <= ilp_pkg::KW_NONE;
				kw_pos_q  <= 3'd0;
				failed_q  <= 1'b0;
			end else begin
				accum_q   <= accum_n;
				phase_q   <= phase_n;
				neg_q     <= neg_n;
				radix_q   <= radix_n;
				prev_us_q <= prev_us_n;
				kw_id_q   <= kw_id_n;
				kw_pos_q  <= kw_pos_n;
				failed_q  <= failed_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			m_tdata <= res_val;
			m_tuser <= res_ok;
		end
	end

	// a failed parse always reports zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == 64'd0))
		else $error("failed result carries a nonzero value");

	// the parse state is back at start after a string ends
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (phase_q == ilp_pkg::PH_START && accum_q == 64'd0
			&& !failed_q && !neg_q))
		else $error("parse state not cleared after end of string");

	// a pending underscore only exists among digits
	assert property (@(posedge clk) disable iff (!arst_n)
		prev_us_q |-> (phase_q == ilp_pkg::PH_DIGITS))
		else $error("underscore flag set outside digit phase");

	// keyword phase always has a candidate
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ilp_pkg::PH_KEYWORD) |-> (kw_id_q != ilp_pkg::KW_NONE))
		else $error("keyword phase without keyword id");

	// the input stage stalls only behind an unread result
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> (last_s1 && m_tvalid && !m_tready))
		else $error("input stage stalled without a pending result");

endmodule

`default_nettype wire

FILE: tb/sv/ilp_result_checker.sv
// ----------------------------------------------------------------------------
// ilp_result_checker
// Passive checker for the integer literal parser. It follows the register
// writes, runs its own parse of every accepted character beat, queues the
// value and ok flag each finished string should give, and compares them with
// the result beats in order.
// ----------------------------------------------------------------------------
module ilp_result_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [1:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] ch
	input  wire logic        s_tuser,  // [0] has_char
	input  wire logic        s_tlast,  // last
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [63:0] m_tdata,  // [63:0] value
	input  wire logic        m_tuser,  // [0] ok
	output int               mismatches,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0]  NOT_A_DIGIT = 8'hFF;
	localparam logic [39:0] TXT_FALSE   = "false";
	localparam logic [39:0] TXT_NULL    = "null";
	localparam logic [39:0] TXT_TRUE    = "true";

	typedef struct packed {
		logic [63:0] value;
		logic        ok;
	} literal_t;

	// register copies
	logic        detect_on;
	logic [1:0]  wsel;
	logic        signed_on;

	// parse state of the string in flight
	logic [63:0] acc;
	logic [2:0]  phase;
	logic        neg;
	logic [1:0]  radix;
	logic        under;
	logic [1:0]  word_id;
	logic [2:0]  word_pos;
	logic        broken;

	literal_t    literal_q[$];
	literal_t    want;
	int          miss_n;

	// largest magnitude for the present sign and register setting
	function automatic logic [63:0] top_magnitude();
		logic [63:0] half;
		half = 64'd1 << ((8 << wsel) - 1);
		if (neg)
			top_magnitude = half;
		else if (signed_on)
			top_magnitude = half - 64'd1;
		else
			top_magnitude = (half << 1) - 64'd1;
	endfunction

	function automatic logic [63:0] radix_base(input logic [1:0] r);
		case (r)
			ilp_pkg::RADIX_BIN: radix_base = 64'd2;
			ilp_pkg::RADIX_OCT: radix_base = 64'd8;
			ilp_pkg::RADIX_HEX: radix_base = 64'd16;
			default:            radix_base = 64'd10;
		endcase
	endfunction

	// digits 0-9, then letters of either case as 10..35
	function automatic logic [7:0] digit_of(input logic [7:0] c);
		logic [7:0] u;
		u = c & ilp_pkg::UPPER_MASK;
		if (c >= ilp_pkg::CH_ZERO && c <= ilp_pkg::CH_NINE)
			digit_of = c - ilp_pkg::CH_ZERO;
		else if (u >= ilp_pkg::CH_UP_A && u <= ilp_pkg::CH_UP_Z)
			digit_of = u - ilp_pkg::CH_UP_A + ilp_pkg::ALPHA_OFS;
		else
			digit_of = NOT_A_DIGIT;
	endfunction

	function automatic int word_len(input logic [1:0] id);
		case (id)
			ilp_pkg::KW_FALSE: word_len = 5;
			ilp_pkg::KW_NULL:  word_len = 4;
			ilp_pkg::KW_TRUE:  word_len = 4;
			default:           word_len = 0;
		endcase
	endfunction

	function automatic logic [7:0] word_char(input logic [1:0] id, input logic [2:0] pos);
		logic [39:0] txt;
		int          n;
		n = word_len(id);
		case (id)
			ilp_pkg::KW_FALSE: txt = TXT_FALSE;
			ilp_pkg::KW_NULL:  txt = TXT_NULL;
			ilp_pkg::KW_TRUE:  txt = TXT_TRUE;
			default:           txt = 40'd0;
		endcase
		if (int'(pos) >= n)
			word_char = 8'h00;
		else
			word_char = txt[(n - 1 - int'(pos)) * 8 +: 8];
	endfunction

	function automatic void clear_parse();
		acc      = 64'd0;
		phase    = ilp_pkg::PH_START;
		neg      = 1'b0;
		radix    = ilp_pkg::RADIX_DEC;
		under    = 1'b0;
		word_id  = ilp_pkg::KW_NONE;
		word_pos = 3'd0;
		broken   = 1'b0;
	endfunction

	// one digit or separator with an exact overflow check
	function automatic void add_digit(input logic [7:0] c);
		logic [63:0] b;
		logic [63:0] lim;
		logic [63:0] d;
		b = radix_base(radix);
		if (neg && !signed_on) begin
			// unsigned negative: only zeros survive
			if (c != ilp_pkg::CH_ZERO)
				broken = 1'b1;
			under = 1'b0;
		end else begin
			lim = top_magnitude();
			d = {56'd0, digit_of(c)};
			if (d < b && (acc < lim / b || (acc == lim / b && d <= lim % b))) begin
				acc = acc * b + d;
				under = 1'b0;
			end else if (phase == ilp_pkg::PH_FIRSTDIG || c != ilp_pkg::CH_UNDER || under) begin
				broken = 1'b1;
			end else begin
				under = 1'b1;
			end
		end
	endfunction

	// first character after the optional sign
	function automatic void begin_body(input logic [7:0] c);
		if (c >= ilp_pkg::CH_ZERO && c <= ilp_pkg::CH_NINE) begin
			radix = ilp_pkg::RADIX_DEC;
			phase = ilp_pkg::PH_FIRSTDIG;
			add_digit(c);
			phase = (c == ilp_pkg::CH_ZERO) ? ilp_pkg::PH_AFTER_ZERO : ilp_pkg::PH_DIGITS;
		end else if (c == ilp_pkg::CH_LO_F) begin
			word_id = ilp_pkg::KW_FALSE;
			word_pos = 3'd1;
			phase = ilp_pkg::PH_KEYWORD;
		end else if (c == ilp_pkg::CH_LO_N) begin
			word_id = ilp_pkg::KW_NULL;
			word_pos = 3'd1;
			phase = ilp_pkg::PH_KEYWORD;
		end else if (c == ilp_pkg::CH_LO_T) begin
			word_id = ilp_pkg::KW_TRUE;
			word_pos = 3'd1;
			phase = ilp_pkg::PH_KEYWORD;
		end else begin
			broken = 1'b1;
		end
	endfunction

	function automatic void parse_char(input logic [7:0] c, input logic fin);
		logic [7:0] low;
		case (phase)
			ilp_pkg::PH_START: begin
				if (c == ilp_pkg::CH_MINUS || c == ilp_pkg::CH_PLUS) begin
					neg = (c == ilp_pkg::CH_MINUS);
					phase = ilp_pkg::PH_BODY0;
				end else begin
					begin_body(c);
				end
			end
			ilp_pkg::PH_BODY0:
				begin_body(c);
			ilp_pkg::PH_AFTER_ZERO: begin
				low = c | ilp_pkg::LOWER_BIT;
				if (detect_on && (low == ilp_pkg::CH_LO_B || low == ilp_pkg::CH_LO_O
						|| low == ilp_pkg::CH_LO_X)) begin
					// a prefix may not end the string
					if (fin) begin
						broken = 1'b1;
					end else begin
						if (low == ilp_pkg::CH_LO_B)
							radix = ilp_pkg::RADIX_BIN;
						else if (low == ilp_pkg::CH_LO_O)
							radix = ilp_pkg::RADIX_OCT;
						else
							radix = ilp_pkg::RADIX_HEX;
						acc = 64'd0;
						under = 1'b0;
						phase = ilp_pkg::PH_FIRSTDIG;
					end
				end else begin
					phase = ilp_pkg::PH_DIGITS;
					add_digit(c);
				end
			end
			ilp_pkg::PH_FIRSTDIG: begin
				add_digit(c);
				phase = ilp_pkg::PH_DIGITS;
			end
			ilp_pkg::PH_DIGITS:
				add_digit(c);
			ilp_pkg::PH_KEYWORD: begin
				if (word_id == ilp_pkg::KW_NONE || int'(word_pos) >= word_len(word_id) ||
						c != word_char(word_id, word_pos))
					broken = 1'b1;
				else
					word_pos = word_pos + 3'd1;
			end
			default:
				broken = 1'b1;
		endcase
	endfunction

	// result of the string that ends now, with the range check once more
	function automatic literal_t close_literal();
		literal_t r;
		r.value = 64'd0;
		r.ok = 1'b0;
		if (!broken) begin
			if (phase == ilp_pkg::PH_DIGITS || phase == ilp_pkg::PH_AFTER_ZERO) begin
				if (!under) begin
					if (neg && !signed_on) begin
						r.ok = 1'b1;
					end else if (acc <= top_magnitude()) begin
						r.ok = 1'b1;
						r.value = neg ? 64'd0 - acc : acc;
					end
				end
			end else if (phase == ilp_pkg::PH_KEYWORD && word_id != ilp_pkg::KW_NONE &&
					int'(word_pos) == word_len(word_id)) begin
				r.ok = 1'b1;
				r.value = (word_id == ilp_pkg::KW_TRUE) ? 64'd1 : 64'd0;
			end
		end
		close_literal = r;
	endfunction

	// follow registers and beats, compare results in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_on = 1'b0;
			wsel = 2'd3;
			signed_on = 1'b1;
			clear_parse();
			literal_q.delete();
			miss_n = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					ilp_pkg::REG_DETECT_BASE: detect_on = cfg_wdata[0];
					ilp_pkg::REG_WIDTH_SEL:   wsel = cfg_wdata;
					ilp_pkg::REG_IS_SIGNED:   signed_on = cfg_wdata[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (literal_q.size() == 0) begin
					$error("result beat with nothing pending: value %h ok %b", m_tdata, m_tuser);
					miss_n++;
				end else begin
					want = literal_q.pop_front();
					if (m_tdata !== want.value) begin
						$error("value: expected %h, got %h", want.value, m_tdata);
						miss_n++;
					end
					if (m_tuser !== want.ok) begin
						$error("ok: expected %b, got %b", want.ok, m_tuser);
						miss_n++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser && !broken)
					parse_char(s_tdata, s_tlast);
				if (s_tlast) begin
					literal_q.push_back(close_literal());
					clear_parse();
				end
			end
		end
		mismatches <= miss_n;
		outstanding <= literal_q.size();
	end

endmodule

FILE: tb/sv/integer_literal_parser_test.sv
// ----------------------------------------------------------------------------
// integer_literal_parser_test
// Drives strings into the integer literal parser: a directed set of edge
// cases across register settings, then random literals, keywords, broken
// and noisy strings under bursty input and a stalling receiver. Results are
// checked by ilp_result_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module integer_literal_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = 2'd0;
	logic [1:0]  cfg_wdata = 2'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;

	int          mismatches;
	int          outstanding;

	// stimulus state
	logic [7:0]  text_q[$];
	bit          offering = 1'b0;
	bit          jam_pending = 1'b0;
	int          burst_left = 0;
	int          sent_items = 0;
	logic        cur_detect = 1'b0;
	logic [1:0]  cur_wsel = 2'd3;
	logic        cur_signed = 1'b1;
	string       word_list[3] = '{"false", "null", "true"};

	integer_literal_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	ilp_result_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("integer_literal_parser regression: fail");
		$finish;
	end

	// result side: stall patterns, one long hold-off on request
	initial begin
		int mode;
		int n;
		wait (arst_n);
		forever begin
			if (jam_pending) begin
				jam_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				n = $urandom_range(4, 40);
				repeat (n) begin
					case (mode)
						0:       m_tready <= 1'b1;
						1:       m_tready <= 1'($urandom_range(0, 1));
						2:       m_tready <= ($urandom_range(0, 4) != 0);
						default: m_tready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// pick the next burst and gap of the character side
	task automatic next_burst();
		int gap;
		burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// offer one beat and wait for it to be taken
	task automatic push_beat(input logic [7:0] c, input logic has, input logic fin);
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= has;
		s_tlast <= fin;
		offering = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (has || fin)
			sent_items++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0)
			next_burst();
	endtask

	// send text_q; optionally mix in empty beats and end on a separate beat
	task automatic send_queue(input bit ends, input bit roughen);
		int i;
		bit split;
		split = ends && (text_q.size() == 0 || (roughen && $urandom_range(0, 9) == 0));
		for (i = 0; i < text_q.size(); i++) begin
			if (roughen && $urandom_range(0, 19) == 0)
				push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			push_beat(text_q[i], 1'b1, ends && !split && i == text_q.size() - 1);
		end
		if (split)
			push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic send_text(input string txt, input bit ends);
		int i;
		text_q.delete();
		for (i = 0; i < txt.len(); i++)
			text_q.push_back(txt[i]);
		send_queue(ends, 1'b0);
	endtask

	// stop offering, let all results drain and the pipeline empty
	task automatic settle();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic db, input logic [1:0] ws, input logic sg);
		cfg_we <= 1'b1;
		cfg_addr <= ilp_pkg::REG_DETECT_BASE;
		cfg_wdata <= {1'b0, db};
		@(posedge clk);
		cfg_addr <= ilp_pkg::REG_WIDTH_SEL;
		cfg_wdata <= ws;
		@(posedge clk);
		cfg_addr <= ilp_pkg::REG_IS_SIGNED;
		cfg_wdata <= {1'b0, sg};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_detect = db;
		cur_wsel = ws;
		cur_signed = sg;
	endtask

	// append v in the given base, with an occasional single separator
	task automatic put_digits(input logic [63:0] v, input logic [1:0] rdx);
		logic [7:0]  digs[$];
		logic [63:0] b;
		logic [63:0] d;
		logic [7:0]  alpha;
		int          i;
		case (rdx)
			ilp_pkg::RADIX_BIN: b = 64'd2;
			ilp_pkg::RADIX_OCT: b = 64'd8;
			ilp_pkg::RADIX_HEX: b = 64'd16;
			default:            b = 64'd10;
		endcase
		if (v == 64'd0)
			digs.push_back(ilp_pkg::CH_ZERO);
		while (v != 64'd0) begin
			d = v % b;
			alpha = $urandom_range(0, 1) ? ilp_pkg::CH_UP_A
			                             : (ilp_pkg::CH_UP_A | ilp_pkg::LOWER_BIT);
			digs.push_front((d < 64'd10) ? ilp_pkg::CH_ZERO + d[7:0]
			                             : alpha + d[7:0] - ilp_pkg::ALPHA_OFS);
			v = v / b;
		end
		for (i = 0; i < digs.size(); i++) begin
			if (i > 0 && $urandom_range(0, 11) == 0)
				text_q.push_back(ilp_pkg::CH_UNDER);
			text_q.push_back(digs[i]);
		end
	endtask

	// well-formed number, biased toward the range limits
	task automatic make_number();
		int          sg;
		int          kind;
		int          i;
		logic [1:0]  rdx;
		logic [7:0]  tag;
		logic [63:0] half;
		logic [63:0] lim;
		logic [63:0] v;
		sg = $urandom_range(0, 2);
		if (sg == 1)
			text_q.push_back(ilp_pkg::CH_PLUS);
		else if (sg == 2)
			text_q.push_back(ilp_pkg::CH_MINUS);
		rdx = ilp_pkg::RADIX_DEC;
		if (cur_detect || $urandom_range(0, 9) == 0)
			rdx = 2'($urandom_range(0, 3));
		if (rdx != ilp_pkg::RADIX_DEC) begin
			text_q.push_back(ilp_pkg::CH_ZERO);
			tag = (rdx == ilp_pkg::RADIX_BIN) ? ilp_pkg::CH_LO_B :
			      (rdx == ilp_pkg::RADIX_OCT) ? ilp_pkg::CH_LO_O : ilp_pkg::CH_LO_X;
			text_q.push_back($urandom_range(0, 1) ? tag : (tag & ilp_pkg::UPPER_MASK));
		end else if ($urandom_range(0, 7) == 0) begin
			text_q.push_back(ilp_pkg::CH_ZERO);
		end
		half = 64'd1 << ((8 << cur_wsel) - 1);
		if (sg == 2)
			lim = half;
		else if (cur_signed)
			lim = half - 64'd1;
		else
			lim = (half << 1) - 64'd1;
		kind = $urandom_range(0, 99);
		if (sg == 2 && !cur_signed && $urandom_range(0, 1))
			kind = 99;
		if (kind < 40) begin
			put_digits(64'($urandom_range(0, 999)), rdx);
		end else if (kind < 60) begin
			put_digits({$urandom, $urandom} & ((half << 1) - 64'd1), rdx);
		end else if (kind < 85) begin
			v = lim - 64'($urandom_range(0, 2));
			if (~lim != 64'd0 && $urandom_range(0, 1))
				v = lim + 64'd1;
			put_digits(v, rdx);
		end else begin
			// runs of zeros, the only digits an unsigned negative may have
			for (i = $urandom_range(1, 4); i > 0; i--)
				text_q.push_back(ilp_pkg::CH_ZERO);
		end
	endtask

	// keyword, sometimes signed, truncated, extended or in the wrong case
	task automatic make_word();
		string w;
		int    i;
		int    sg;
		int    mut;
		int    n;
		sg = $urandom_range(0, 2);
		if (sg == 1)
			text_q.push_back(ilp_pkg::CH_PLUS);
		else if (sg == 2)
			text_q.push_back(ilp_pkg::CH_MINUS);
		w = word_list[$urandom_range(0, 2)];
		mut = $urandom_range(0, 9);
		n = (mut == 0) ? w.len() - $urandom_range(1, 2) : w.len();
		for (i = 0; i < n; i++)
			text_q.push_back((mut == 2 && i == n - 1) ? (w[i] & ilp_pkg::UPPER_MASK) : w[i]);
		if (mut == 1)
			text_q.push_back($urandom_range(0, 1) ? ilp_pkg::CH_LO_T : ilp_pkg::CH_ZERO);
	endtask

	// number with one defect
	task automatic make_broken();
		int idx;
		make_number();
		idx = $urandom_range(0, text_q.size() - 1);
		case ($urandom_range(0, 3))
			0: text_q[idx] = 8'($urandom_range(0, 255));
			1: text_q.push_back(ilp_pkg::CH_UNDER);
			2: begin
				text_q.insert(idx + 1, ilp_pkg::CH_UNDER);
				text_q.insert(idx + 1, ilp_pkg::CH_UNDER);
			end
			default: text_q.push_front(ilp_pkg::CH_UNDER);
		endcase
	endtask

	// raw bytes, partly drawn from characters the parser cares about
	task automatic make_noise();
		int n;
		n = $urandom_range(0, 6);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0:       text_q.push_back(ilp_pkg::CH_PLUS);
				1:       text_q.push_back(ilp_pkg::CH_MINUS);
				2:       text_q.push_back(ilp_pkg::CH_UNDER);
				3:       text_q.push_back(ilp_pkg::CH_ZERO);
				4:       text_q.push_back(ilp_pkg::CH_LO_X);
				5:       text_q.push_back(ilp_pkg::CH_UP_Z);
				default: text_q.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// bare sign or bare prefix
	task automatic make_stub();
		if ($urandom_range(0, 1))
			text_q.push_back($urandom_range(0, 1) ? ilp_pkg::CH_MINUS : ilp_pkg::CH_PLUS);
		if ($urandom_range(0, 2) != 0) begin
			text_q.push_back(ilp_pkg::CH_ZERO);
			case ($urandom_range(0, 2))
				0:       text_q.push_back(ilp_pkg::CH_LO_B);
				1:       text_q.push_back(ilp_pkg::CH_LO_O);
				default: text_q.push_back(ilp_pkg::CH_LO_X & ilp_pkg::UPPER_MASK);
			endcase
		end
	endtask

	task automatic make_literal();
		int k;
		text_q.delete();
		k = $urandom_range(0, 99);
		if (k < 60)
			make_number();
		else if (k < 70)
			make_word();
		else if (k < 84)
			make_broken();
		else if (k < 94)
			make_noise();
		else
			make_stub();
	endtask

	// main sequence
	initial begin
		int blk;
		int start_n;
		int waited;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: decimal only, signed 64 bit
		push_beat(8'hFF, 1'b0, 1'b1);
		send_text("0", 1'b1);
		send_text("9223372036854775807", 1'b1);
		send_text("-9223372036854775808", 1'b1);
		send_text("9223372036854775808", 1'b1);
		send_text("+12_34", 1'b1);
		send_text("_1", 1'b1);
		send_text("1_", 1'b1);
		send_text("1__2", 1'b1);
		send_text("-", 1'b1);
		send_text("false", 1'b1);
		send_text("-true", 1'b1);
		send_text("+null", 1'b1);
		send_text("nul", 1'b1);
		send_text("truex", 1'b1);
		send_text("0x1F", 1'b1);
		send_text("zZ", 1'b1);
		push_beat(8'hFF, 1'b1, 1'b1);
		// empty beat inside a string, and a string closed by an empty beat
		send_text("4", 1'b0);
		push_beat(8'h00, 1'b0, 1'b0);
		send_text("2", 1'b1);
		send_text("77", 1'b0);
		push_beat(8'h80, 1'b0, 1'b1);
		// narrowing the width in the middle of a string
		send_text("1000", 1'b0);
		settle();
		set_config(1'b0, 2'd0, 1'b1);
		send_text("0", 1'b1);
		settle();

		// 8 bit unsigned with prefixes
		set_config(1'b1, 2'd0, 1'b0);
		send_text("255", 1'b1);
		send_text("256", 1'b1);
		send_text("0XFF", 1'b1);
		send_text("0x100", 1'b1);
		send_text("0b11111111", 1'b1);
		send_text("0o377", 1'b1);
		send_text("0x", 1'b1);
		send_text("-000", 1'b1);
		send_text("-0_0", 1'b1);
		send_text("-1", 1'b1);
		send_text("0b2", 1'b1);
		send_text("0x_f", 1'b1);
		// becoming signed after the sign of a string
		send_text("-0", 1'b0);
		settle();
		set_config(1'b1, 2'd0, 1'b1);
		send_text("5", 1'b1);
		send_text("127", 1'b1);
		send_text("-128", 1'b1);
		send_text("-129", 1'b1);
		send_text("-0x80", 1'b1);
		settle();

		// 64 bit unsigned limits
		set_config(1'b1, 2'd3, 1'b0);
		send_text("18446744073709551615", 1'b1);
		send_text("18446744073709551616", 1'b1);
		send_text("0xFFFFFFFFFFFFFFFF", 1'b1);
		send_text("0o1777777777777777777777", 1'b1);
		send_text("-0b0", 1'b1);

		// random strings over a range of register settings
		for (blk = 0; blk < 8; blk++) begin
			settle();
			case (blk)
				0:       set_config(1'b1, 2'd0, 1'b1);
				1:       set_config(1'b0, 2'd0, 1'b0);
				2:       set_config(1'b1, 2'd3, 1'b0);
				3:       set_config(1'b1, 2'd1, 1'b1);
				4:       set_config(1'b0, 2'd2, 1'b0);
				5:       set_config(1'b1, 2'd3, 1'b1);
				default: set_config(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
				                    1'($urandom_range(0, 1)));
			endcase
			if (blk == 1)
				jam_pending = 1'b1;
			start_n = sent_items;
			while (sent_items - start_n < 105) begin
				make_literal();
				send_queue(1'b1, 1'b1);
			end
		end

		// drain and verdict
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
		@(posedge clk);
		waited = 0;
		while (outstanding != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (outstanding != 0)
			$error("%0d results never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("integer_literal_parser regression: pass");
		else
			$display("integer_literal_parser regression: fail");
		$finish;
	end

endmodule

FILE: files.f
rtl/ilp_pkg.sv
rtl/integer_literal_parser.sv
tb/sv/ilp_result_checker.sv
tb/sv/integer_literal_parser_test.sv
